### rtl/core/hcbe_pkg.sv
// Shared types and constants for the Huffman code builder / encoder.
// No dependencies.
package hcbe_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int COUNT_WIDTH  = 32;
  localparam int MAX_CODE_LEN = 64;
  localparam int NODE_COUNT   = 2 * NUM_SYMBOLS - 1;
  localparam int SYM_W        = 8;
  localparam int NODE_W       = 9;
  localparam int LEN_W        = 7;
  localparam int CNT_OUT_W    = 9;
  localparam int WEIGHT_W     = 40;
  localparam int QIDX_W       = 8;
  localparam int PADDR_W      = 3;

  localparam logic [1:0] FUNC_COUNT  = 2'd0;
  localparam logic [1:0] FUNC_BUILD  = 2'd1;
  localparam logic [1:0] FUNC_ENCODE = 2'd2;

  localparam logic REG_PRINTABLE = 1'b0;

  localparam logic [SYM_W-1:0] PRINT_LO = 8'h20;
  localparam logic [SYM_W-1:0] PRINT_HI = 8'h7E;

  // one node of the tree; leaves also hold the histogram count
  typedef struct packed {
    logic [COUNT_WIDTH-1:0]  count;
    logic [NODE_W-1:0]       parent;
    logic                    side;
    logic [LEN_W-1:0]        len;
    logic [MAX_CODE_LEN-1:0] code;
  } node_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   node;
  } queue_t;

endpackage

### rtl/core/hcbe_item_if.sv
// Input channel: one beat carries func and symbol.
// Depends on hcbe_pkg.
interface hcbe_item_if;
  import hcbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [SYM_W-1:0] symbol;
  modport source(output valid, func, symbol, input ready);
  modport sink(input valid, func, symbol, output ready);
endinterface

### rtl/core/hcbe_result_if.sv
// Output channel: one beat carries code, length, symbol count and status.
// Depends on hcbe_pkg.
interface hcbe_result_if;
  import hcbe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MAX_CODE_LEN-1:0] code_bits;
  logic [LEN_W-1:0]        code_len;
  logic [CNT_OUT_W-1:0]    symbol_count;
  logic                    status;
  modport source(output valid, code_bits, code_len, symbol_count, status, input ready);
  modport sink(input valid, code_bits, code_len, symbol_count, status, output ready);
endinterface

### rtl/core/huffman_code_builder_encoder.sv
// Huffman code builder / encoder. Count and encode beats each pass through the
// read-modify-write of the node memory (read, use, result slot). A build's time
// is dominated by the insertion walk of the sorted queue. After rst (synchronous,
// active high) a clearing pass zeroes the 256 leaf entries; items are held off
// meanwhile, config still works.
module huffman_code_builder_encoder (
  input  logic                         clk,
  input  logic                         rst,
  hcbe_item_if.sink                    items,
  hcbe_result_if.source                results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hcbe_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hcbe_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CNT, S_ENC, S_RES,
    S_BINIT, S_LRD, S_LEAF, S_LNEXT,
    S_PSTART, S_PCMP, S_PINS,
    S_POPA, S_TAKEA, S_TAKEB, S_PARA, S_PARB, S_MNEXT,
    S_CRD, S_CPAR, S_CCALC, S_CNEXT
  } state_t;

  state_t state;

  // config and status
  logic printable_only;
  logic table_built;

  // working registers
  logic [SYM_W-1:0]    sym;
  logic [NODE_W-1:0]   idx;        // leaf scan, clear and code pass index
  logic [CNT_OUT_W-1:0] n_sym;     // distinct symbols
  logic [CNT_OUT_W-1:0] merges;
  logic [NODE_W-1:0]   next_node;
  logic [QIDX_W-1:0]   head;
  logic [CNT_OUT_W-1:0] qlen;
  logic [QIDX_W-1:0]   k;
  logic [WEIGHT_W-1:0] push_w;
  logic [NODE_W-1:0]   push_node;
  logic                push_from_merge;
  queue_t              ent_a, ent_b;
  node_t               ent;

  // pending result
  logic [MAX_CODE_LEN-1:0] res_bits;
  logic [LEN_W-1:0]        res_len;
  logic [CNT_OUT_W-1:0]    res_cnt;
  logic                    res_status;

  // memories
  node_t  node_mem [NODE_COUNT];
  queue_t q_mem    [NUM_SYMBOLS];

  logic [NODE_W-1:0] node_raddr, node_waddr;
  logic              node_we;
  node_t             node_rdata, node_wdata;
  logic [QIDX_W-1:0] q_raddr, q_waddr;
  logic              q_we;
  queue_t            q_rdata, q_wdata;

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[q_raddr];
  end

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PRINTABLE) ? {31'd0, printable_only} : 32'd0;
  wire cfg_wr = psel && penable && pwrite;

  // decode helpers
  wire item_beat = items.valid && items.ready;
  wire slot_free = !results.valid || results.ready;
  wire cnt_ok    = !printable_only || (sym >= PRINT_LO && sym <= PRINT_HI);
  wire cnt_sat   = &node_rdata.count;
  wire q_larger  = q_rdata.weight >= push_w;   // new entry goes before it
  wire is_inner  = idx[NODE_W-1];
  wire few_syms  = n_sym < CNT_OUT_W'(2);
  wire [NODE_W-1:0] root_idx = next_node - NODE_W'(1);
  wire [QIDX_W-1:0] q_tail   = head + qlen[QIDX_W-1:0] - QIDX_W'(1);

  // child code from parent entry (node_rdata) and saved side bit
  node_t child;
  always_comb begin
    child = ent;
    if (node_rdata.len < LEN_W'(MAX_CODE_LEN)) begin
      child.len  = node_rdata.len + LEN_W'(1);
      child.code = {node_rdata.code[MAX_CODE_LEN-2:0], ent.side};
    end else begin
      child.len  = node_rdata.len;
      child.code = node_rdata.code;
    end
  end

  assign items.ready = (state == S_IDLE);

  // memory port control
  always_comb begin
    node_raddr = idx;
    node_we    = 1'b0;
    node_waddr = idx;
    node_wdata = node_rdata;
    q_raddr    = head;
    q_we       = 1'b0;
    q_waddr    = head;
    q_wdata    = '{weight: push_w, node: push_node};
    unique case (state)
      S_CLR: begin
        node_we    = 1'b1;
        node_wdata = '0;
      end
      S_IDLE: node_raddr = {1'b0, items.symbol};
      S_CNT: begin
        node_we    = cnt_ok && !cnt_sat;
        node_waddr = {1'b0, sym};
        node_wdata.count = node_rdata.count + COUNT_WIDTH'(1);
      end
      S_PSTART: begin
        q_raddr = q_tail;
        q_we    = (qlen == '0);
      end
      S_PCMP: begin
        q_we    = 1'b1;
        q_waddr = head + k;
        if (q_larger) q_wdata = q_rdata;
        q_raddr = head + k - QIDX_W'(2);
      end
      S_PINS: q_we = 1'b1;
      S_TAKEA: q_raddr = head + QIDX_W'(1);
      // fetch the 0-branch node so its entry is rewritten intact
      S_TAKEB: node_raddr = ent_a.node;
      S_PARA: begin
        node_we    = 1'b1;
        node_waddr = ent_a.node;
        node_wdata.parent = next_node;
        node_wdata.side   = 1'b0;
        node_raddr = ent_b.node;
      end
      S_PARB: begin
        node_we    = 1'b1;
        node_waddr = ent_b.node;
        node_wdata.parent = next_node;
        node_wdata.side   = 1'b1;
      end
      S_CPAR: begin
        node_wdata.len  = '0;
        node_wdata.code = '0;
        if (is_inner) node_we = !few_syms && idx == root_idx;
        else          node_we = node_rdata.count == '0 || few_syms;
        node_raddr = node_rdata.parent;
      end
      S_CCALC: begin
        node_we    = 1'b1;
        node_wdata = child;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      idx            <= '0;
      printable_only <= 1'b1;
      table_built    <= 1'b0;
      results.valid  <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_PRINTABLE) printable_only <= pwdata[0];
      if (state == S_RES && slot_free) results.valid <= 1'b1;
      else if (results.ready)          results.valid <= 1'b0;

      unique case (state)
        S_CLR: begin
          idx <= idx + NODE_W'(1);
          if (idx[QIDX_W-1:0] == QIDX_W'(NUM_SYMBOLS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (item_beat) begin
          sym        <= items.symbol;
          res_bits   <= '0;
          res_len    <= '0;
          res_cnt    <= '0;
          res_status <= 1'b0;
          priority case (items.func)
            FUNC_COUNT:  state <= S_CNT;
            FUNC_BUILD:  state <= S_BINIT;
            FUNC_ENCODE: state <= S_ENC;
            default:     state <= S_RES;
          endcase
        end
        S_CNT: state <= S_RES;
        S_ENC: begin
          if (table_built) begin
            res_bits <= node_rdata.code;
            res_len  <= node_rdata.len;
          end else begin
            res_status <= 1'b1;
          end
          state <= S_RES;
        end
        S_RES: if (slot_free) begin
          results.code_bits    <= res_bits;
          results.code_len     <= res_len;
          results.symbol_count <= res_cnt;
          results.status       <= res_status;
          state                <= S_IDLE;
        end
        // leaf scan: push every counted symbol
        S_BINIT: begin
          idx   <= '0;
          n_sym <= '0;
          head  <= '0;
          qlen  <= '0;
          state <= S_LRD;
        end
        S_LRD: state <= S_LEAF;
        S_LEAF: begin
          if (node_rdata.count != '0) begin
            push_w          <= WEIGHT_W'(node_rdata.count);
            push_node       <= idx;
            push_from_merge <= 1'b0;
            n_sym           <= n_sym + CNT_OUT_W'(1);
            state           <= S_PSTART;
          end else begin
            state <= S_LNEXT;
          end
        end
        S_LNEXT: begin
          if (idx[QIDX_W-1:0] == QIDX_W'(NUM_SYMBOLS - 1)) begin
            merges    <= '0;
            next_node <= NODE_W'(NUM_SYMBOLS);
            if (few_syms) begin
              idx   <= NODE_W'(NODE_COUNT - 1);
              state <= S_CRD;
            end else begin
              state <= S_POPA;
            end
          end else begin
            idx   <= idx + NODE_W'(1);
            state <= S_LRD;
          end
        end
        // sorted insert: walk down from the tail, shifting entries of equal or greater weight up
        S_PSTART: begin
          k <= qlen[QIDX_W-1:0];
          if (qlen == '0) begin
            qlen  <= qlen + CNT_OUT_W'(1);
            state <= push_from_merge ? S_MNEXT : S_LNEXT;
          end else begin
            state <= S_PCMP;
          end
        end
        S_PCMP: begin
          if (q_larger) begin
            k <= k - QIDX_W'(1);
            if (k == QIDX_W'(1)) state <= S_PINS;
          end else begin
            qlen  <= qlen + CNT_OUT_W'(1);
            state <= push_from_merge ? S_MNEXT : S_LNEXT;
          end
        end
        S_PINS: begin
          qlen  <= qlen + CNT_OUT_W'(1);
          state <= push_from_merge ? S_MNEXT : S_LNEXT;
        end
        // merge the two lightest entries
        S_POPA: state <= S_TAKEA;
        S_TAKEA: begin
          ent_a <= q_rdata;
          state <= S_TAKEB;
        end
        S_TAKEB: begin
          ent_b <= q_rdata;
          head  <= head + QIDX_W'(2);
          qlen  <= qlen - CNT_OUT_W'(2);
          state <= S_PARA;
        end
        S_PARA: state <= S_PARB;
        S_PARB: begin
          push_w          <= ent_a.weight + ent_b.weight;
          push_node       <= next_node;
          push_from_merge <= 1'b1;
          state           <= S_PSTART;
        end
        S_MNEXT: begin
          next_node <= next_node + NODE_W'(1);
          merges    <= merges + CNT_OUT_W'(1);
          if (merges + CNT_OUT_W'(2) == n_sym) begin
            idx   <= NODE_W'(NODE_COUNT - 1);
            state <= S_CRD;
          end else begin
            state <= S_POPA;
          end
        end
        // code pass, root downward: child code = parent code plus side bit
        S_CRD: state <= S_CPAR;
        S_CPAR: begin
          ent <= node_rdata;
          if (is_inner) begin
            if (few_syms || idx >= root_idx) state <= S_CNEXT;
            else                             state <= S_CCALC;
          end else begin
            if (node_rdata.count == '0 || few_syms) state <= S_CNEXT;
            else                                    state <= S_CCALC;
          end
        end
        S_CCALC: state <= S_CNEXT;
        S_CNEXT: begin
          if (idx == '0) begin
            table_built <= 1'b1;
            res_cnt     <= n_sym;
            state       <= S_RES;
          end else begin
            idx   <= idx - NODE_W'(1);
            state <= S_CRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one item at a time: no beat right after a beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_beat |=> !items.ready)
    else $error("item accepted while busy");

  // queue never grows past its depth
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_PSTART || state == S_PCMP || state == S_PINS) |->
      qlen < CNT_OUT_W'(NUM_SYMBOLS))
    else $error("queue overflow");

  // once built, the table stays built
  a_built_sticky: assert property (@(posedge clk) disable iff (rst)
    table_built |=> table_built)
    else $error("table_built dropped");

endmodule
